/* rtl/callsite_stat_hash_table_core_assert.svh */
// Assertion macros shared by the statistics table RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef CALLSITE_STAT_HASH_TABLE_CORE_ASSERT_SVH
`define CALLSITE_STAT_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/csht_pkg.sv */
// Shared types and constants of the statistics table.
// No dependencies.
package csht_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int TOP_MAX_DEF     = 16;

  localparam logic [4:0]  TOP_COUNT_RESET = 5'd8;
  localparam logic [63:0] HASH_MUL1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_MUL2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_ACCUM   = 3'd1,
    ST_DROPPED = 3'd2,
    ST_CLEARED = 3'd3,
    ST_ENTRY   = 3'd4,
    ST_EMPTY   = 3'd5
  } status_e;

  typedef struct packed {
    logic        used;
    logic [63:0] site;
    logic [19:0] line;
    logic [47:0] bytes;
    logic [31:0] allocs;
  } slot_t;

  typedef struct packed {
    logic latch;
    logic probe_rd;
    logic probe_ck;
    logic sweep;
    logic scan_rd;
    logic scan_ck;
    logic emit_rd;
    logic emit_ck;
    logic emit_clear;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    hash_done;
    logic    free;
    logic    match;
    logic    probe_end;
    logic    slot_last;
    logic    emit_last;
    logic    rep_empty;
  } sts_t;

endpackage

/* rtl/csht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/csht_hash.sv */
// Key hash: two mix-and-multiply rounds on one shared 32x32 multiplier.
// Depends on csht_pkg.
module csht_hash #(
  parameter int IW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   site_i,
  input  logic [19:0]   line_i,
  output logic          done_o,
  output logic [IW-1:0] home_o
);
  import csht_pkg::*;

  logic [3:0]  cnt_q;
  logic        run_q;
  logic [63:0] x_q, acc_q, p_q, t, hfin, mul_c;
  logic [31:0] mul_a, mul_b;

  always_comb begin
    mul_c = (cnt_q < 4'd5) ? HASH_MUL1 : HASH_MUL2;
    mul_a = x_q[31:0];
    mul_b = mul_c[31:0];
    unique case (cnt_q)
      4'd1, 4'd6: mul_a = x_q[63:32];
      4'd2, 4'd7: mul_b = mul_c[63:32];
      default: ;
    endcase
    t    = acc_q ^ {44'b0, line_i};
    hfin = acc_q ^ (acc_q >> 33);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else if (start_i) begin
      cnt_q <= '0;
      run_q <= 1'b1;
    end else if (run_q) begin
      if (cnt_q == 4'd9) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  // Low 64 bits of a 64x64 product: lo*lo plus both cross terms shifted up.
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (start_i) begin
      x_q <= site_i ^ (site_i >> 33);
    end else if (run_q) begin
      unique case (cnt_q)
        4'd1, 4'd6:             acc_q <= p_q;
        4'd2, 4'd3, 4'd7, 4'd8: acc_q <= acc_q + {p_q[31:0], 32'b0};
        4'd4:                   x_q   <= t ^ (t >> 33);
        default: ;
      endcase
    end
  end

  assign done_o = run_q && (cnt_q == 4'd9);
  assign home_o = hfin[IW-1:0];
endmodule

/* rtl/csht_ctrl.sv */
// Sequencer of the statistics table: issues datapath commands per state.
// Depends on csht_pkg.
module csht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  csht_pkg::sts_t sts_i,
  output csht_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import csht_pkg::*;

  typedef enum logic [9:0] {
    S_INIT = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_HASH = 10'b0000000100,
    S_PRD  = 10'b0000001000,
    S_PCK  = 10'b0000010000,
    S_CLR  = 10'b0000100000,
    S_SRD  = 10'b0001000000,
    S_SCK  = 10'b0010000000,
    S_ERD  = 10'b0100000000,
    S_ECK  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.slot_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (sts_i.op)
            OP_RECORD: state_d = S_HASH;
            OP_CLEAR:  state_d = S_CLR;
            OP_REPORT: begin
              if (sts_i.rep_empty) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                state_d = S_SRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) state_d = S_PRD;
      end
      S_PRD: begin
        cmd_o.probe_rd = 1'b1;
        state_d = S_PCK;
      end
      S_PCK: begin
        cmd_o.probe_ck = 1'b1;
        state_d = (sts_i.free || sts_i.match || sts_i.probe_end) ? S_IDLE : S_PRD;
      end
      S_CLR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.slot_last) begin
          cmd_o.emit_clear = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_SCK;
      end
      S_SCK: begin
        cmd_o.scan_ck = 1'b1;
        state_d = sts_i.slot_last ? S_ERD : S_SRD;
      end
      S_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = S_ECK;
      end
      S_ECK: begin
        cmd_o.emit_ck = 1'b1;
        state_d = sts_i.emit_last ? S_IDLE : S_ERD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
endmodule

/* rtl/csht_dp.sv */
// Datapath of the statistics table: slot RAM, hash, probe, top list, results.
// Depends on csht_pkg, csht_ram and csht_hash.
module csht_dp #(
  parameter int TABLE_SLOTS = csht_pkg::TABLE_SLOTS_DEF,
  parameter int TOP_MAX     = csht_pkg::TOP_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  csht_pkg::cmd_t cmd_i,
  output csht_pkg::sts_t sts_o,
  input  logic           cfg_we_i,
  input  logic [4:0]     cfg_data_i,
  input  logic [1:0]     opcode_i,
  input  logic [63:0]    site_id_i,
  input  logic [19:0]    line_i,
  input  logic [31:0]    alloc_size_i,
  output logic           valid_o,
  output logic [2:0]     status_o,
  output logic [63:0]    entry_site_o,
  output logic [19:0]    entry_line_o,
  output logic [47:0]    entry_bytes_o,
  output logic [31:0]    entry_allocs_o,
  output logic [3:0]     rank_o,
  output logic           last_o
);
  import csht_pkg::*;

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int UW = $clog2(TABLE_SLOTS + 1);
  localparam int KW = $clog2(TOP_MAX + 1);
  localparam int EW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;

  logic [4:0]    top_count_q;
  logic [UW-1:0] used_q;
  logic [63:0]   site_q;
  logic [19:0]   line_q;
  logic [31:0]   size_q;
  logic [IW-1:0] probe_idx_q, probe_cnt_q, slot_q;
  logic [IW-1:0] top_idx_q [TOP_MAX];
  logic [47:0]   top_bytes_q [TOP_MAX];
  logic [IW-1:0] top_idx_d [TOP_MAX];
  logic [47:0]   top_bytes_d [TOP_MAX];
  logic [KW-1:0] n_q, k;
  logic [EW-1:0] emit_q;

  logic          valid_q, last_q;
  logic [2:0]    status_q;
  logic [63:0]   osite_q;
  logic [19:0]   oline_q;
  logic [47:0]   obytes_q;
  logic [31:0]   oallocs_q;
  logic [3:0]    rank_q;

  slot_t         rdata, wdata;
  logic          we;
  logic [IW-1:0] raddr, waddr;
  logic          hash_done;
  logic [IW-1:0] home;
  logic [48:0]   sum;
  logic [47:0]   bytes_new;
  logic [31:0]   allocs_new;
  logic          free, match, emit_last;
  logic [TOP_MAX-1:0] gt;
  logic          gtk, ins;
  int            pos, lim;

  csht_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  csht_hash #(.IW(IW)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.latch && (opcode_e'(opcode_i) == OP_RECORD)),
    .site_i  (site_id_i),
    .line_i  (line_q),
    .done_o  (hash_done),
    .home_o  (home)
  );

  always_comb begin
    k = (32'(top_count_q) > TOP_MAX) ? KW'(TOP_MAX) : KW'(top_count_q);
    free  = !rdata.used;
    match = rdata.used && (rdata.site == site_q) && (rdata.line == line_q);
    sum   = {1'b0, rdata.bytes} + {17'b0, size_q};
    bytes_new  = sum[48] ? '1 : sum[47:0];
    allocs_new = (rdata.allocs == 32'hFFFF_FFFF) ? rdata.allocs : rdata.allocs + 32'd1;
    emit_last  = (int'(emit_q) + 1 == int'(n_q));
  end

  // RAM ports: sweeps write empty slots, a probe claims or updates a slot.
  always_comb begin
    we    = 1'b0;
    waddr = probe_idx_q;
    wdata = '0;
    priority if (cmd_i.sweep) begin
      we    = 1'b1;
      waddr = slot_q;
    end else if (cmd_i.probe_ck && free) begin
      we    = 1'b1;
      wdata = '{used: 1'b1, site: site_q, line: line_q, bytes: {16'b0, size_q},
                allocs: 32'd1};
    end else if (cmd_i.probe_ck && match) begin
      we    = 1'b1;
      wdata = '{used: 1'b1, site: site_q, line: line_q, bytes: bytes_new,
                allocs: allocs_new};
    end
    priority if (cmd_i.probe_rd) raddr = probe_idx_q;
    else if (cmd_i.scan_rd)      raddr = slot_q;
    else if (cmd_i.emit_rd)      raddr = top_idx_q[emit_q];
    else                         raddr = probe_idx_q;
  end

  // Sorted insert into the top list; strict compare keeps lower slots first on ties.
  always_comb begin
    gtk = 1'b0;
    pos = int'(n_q);
    lim = (n_q < k) ? int'(n_q) : int'(k) - 1;
    for (int j = 0; j < TOP_MAX; j++) begin
      gt[j] = (j < int'(n_q)) && (rdata.bytes > top_bytes_q[j]);
    end
    for (int j = 0; j < TOP_MAX; j++) begin
      if (j == int'(k) - 1) gtk = gt[j];
    end
    for (int j = TOP_MAX - 1; j >= 0; j--) begin
      if (gt[j]) pos = j;
    end
    ins = rdata.used && ((n_q < k) || gtk);
    top_idx_d   = top_idx_q;
    top_bytes_d = top_bytes_q;
    for (int j = 0; j < TOP_MAX; j++) begin
      if (j == pos) begin
        top_idx_d[j]   = slot_q;
        top_bytes_d[j] = rdata.bytes;
      end else if (j > 0 && j > pos && j <= lim) begin
        top_idx_d[j]   = top_idx_q[j-1];
        top_bytes_d[j] = top_bytes_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TOP_COUNT_RESET;
      used_q      <= '0;
      probe_idx_q <= '0;
      probe_cnt_q <= '0;
      slot_q      <= '0;
      n_q         <= '0;
      emit_q      <= '0;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) top_count_q <= cfg_data_i;
      if (cmd_i.latch) begin
        n_q         <= '0;
        emit_q      <= '0;
        probe_cnt_q <= '0;
        if (opcode_e'(opcode_i) == OP_CLEAR) used_q <= '0;
      end
      if (hash_done) probe_idx_q <= home;
      if (cmd_i.sweep || cmd_i.scan_ck) slot_q <= slot_q + IW'(1);
      if (cmd_i.probe_ck) begin
        if (free) used_q <= used_q + UW'(1);
        if (free || match || sts_o.probe_end) begin
          valid_q <= 1'b1;
        end else begin
          probe_idx_q <= probe_idx_q + IW'(1);
          probe_cnt_q <= probe_cnt_q + IW'(1);
        end
      end
      if (cmd_i.scan_ck && ins && n_q < k) n_q <= n_q + KW'(1);
      if (cmd_i.emit_ck) begin
        emit_q  <= emit_q + EW'(1);
        valid_q <= 1'b1;
      end
      if (cmd_i.emit_clear || cmd_i.emit_empty) valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      site_q <= site_id_i;
      line_q <= line_i;
      size_q <= alloc_size_i;
    end
    if (cmd_i.scan_ck && ins) begin
      top_idx_q   <= top_idx_d;
      top_bytes_q <= top_bytes_d;
    end
    rank_q <= 4'd0;
    last_q <= 1'b1;
    if (cmd_i.probe_ck) begin
      osite_q <= site_q;
      oline_q <= line_q;
      priority if (free) begin
        status_q  <= ST_NEW;
        obytes_q  <= {16'b0, size_q};
        oallocs_q <= 32'd1;
      end else if (match) begin
        status_q  <= ST_ACCUM;
        obytes_q  <= bytes_new;
        oallocs_q <= allocs_new;
      end else begin
        status_q  <= ST_DROPPED;
        obytes_q  <= '0;
        oallocs_q <= '0;
      end
    end else if (cmd_i.emit_ck) begin
      status_q  <= ST_ENTRY;
      osite_q   <= rdata.site;
      oline_q   <= rdata.line;
      obytes_q  <= rdata.bytes;
      oallocs_q <= rdata.allocs;
      rank_q    <= 4'(emit_q);
      last_q    <= emit_last;
    end else begin
      status_q  <= cmd_i.emit_clear ? ST_CLEARED : ST_EMPTY;
      osite_q   <= '0;
      oline_q   <= '0;
      obytes_q  <= '0;
      oallocs_q <= '0;
    end
  end

  always_comb begin
    sts_o.op        = opcode_e'(opcode_i);
    sts_o.hash_done = hash_done;
    sts_o.free      = free;
    sts_o.match     = match;
    sts_o.probe_end = (probe_cnt_q == IW'(TABLE_SLOTS - 1));
    sts_o.slot_last = (slot_q == '1);
    sts_o.emit_last = emit_last;
    sts_o.rep_empty = (k == '0) || (used_q == '0);
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign entry_site_o   = osite_q;
  assign entry_line_o   = oline_q;
  assign entry_bytes_o  = obytes_q;
  assign entry_allocs_o = oallocs_q;
  assign rank_o         = rank_q;
  assign last_o         = last_q;
endmodule

/* rtl/callsite_stat_hash_table_core.sv */
// Top level of the per-key statistics table: controller plus datapath.
// Depends on csht_pkg, csht_ctrl, csht_dp and the assertion macro header.
//
// Items are taken with start_i while busy_o is low; every result appears on
// valid_o for one cycle and cannot be held off. After reset the block sweeps
// all TABLE_SLOTS slots, one a cycle, before it takes an item (configuration
// writes are taken throughout). A record hashes the key on the shared 32x32
// multiplier, then reads (S_PRD) and checks (S_PCK) one slot after another,
// since every probe waits on the registered slot RAM read; a full table probes
// every slot. A clear sweeps all TABLE_SLOTS slots. A non-empty report scans
// all slots (S_SRD, S_SCK), then reads out each kept entry (S_ERD, S_ECK).
`include "callsite_stat_hash_table_core_assert.svh"

module callsite_stat_hash_table_core #(
  parameter int TABLE_SLOTS = csht_pkg::TABLE_SLOTS_DEF,
  parameter int TOP_MAX     = csht_pkg::TOP_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] site_id_i,
  input  logic [19:0] line_i,
  input  logic [31:0] alloc_size_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [63:0] entry_site_o,
  output logic [19:0] entry_line_o,
  output logic [47:0] entry_bytes_o,
  output logic [31:0] entry_allocs_o,
  output logic [3:0]  rank_o,
  output logic        last_o
);
  import csht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  csht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  csht_dp #(.TABLE_SLOTS(TABLE_SLOTS), .TOP_MAX(TOP_MAX)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .site_id_i      (site_id_i),
    .line_i         (line_i),
    .alloc_size_i   (alloc_size_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .entry_site_o   (entry_site_o),
    .entry_line_o   (entry_line_o),
    .entry_bytes_o  (entry_bytes_o),
    .entry_allocs_o (entry_allocs_o),
    .rank_o         (rank_o),
    .last_o         (last_o)
  );

  `CSHT_ASSERT_NOW(a_single_last, valid_o && (status_o != ST_ENTRY), last_o, "non-report result not last")
  `CSHT_ASSERT_NEXT(a_record_busy, start_i && !busy_o && (opcode_i == OP_RECORD), busy_o, "record not held busy")
  `CSHT_ASSERT_NEXT(a_report_more, valid_o && (status_o == ST_ENTRY) && !last_o, busy_o, "report ended early")
endmodule
